/* rtl/icaf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icaf_pkg
// Shared constants, types and the arctangent table for the attitude filter.
// ----------------------------------------------------------------------------
package icaf_pkg;

	localparam int unsigned AngleFracBitsDef = 16;
	localparam int unsigned CordicStepsDef   = 16;
	localparam int unsigned TabFrac          = 24;
	localparam int unsigned CordicW          = 34;
	localparam int unsigned BlendGW          = 34;
	localparam int unsigned CfgIdxW          = 4;
	localparam int unsigned CfgDataW         = 16;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ACCEL_RANGE = 4'd0,
		REG_GYRO_RANGE  = 4'd1,
		REG_ACCEL_OFF_X = 4'd2,
		REG_ACCEL_OFF_Y = 4'd3,
		REG_ACCEL_OFF_Z = 4'd4,
		REG_GYRO_OFF_X  = 4'd5,
		REG_GYRO_OFF_Y  = 4'd6,
		REG_GYRO_OFF_Z  = 4'd7
	} cfg_reg_t;

	// Start and finish strobes between the sequencer and one engine.
	typedef struct packed {
		logic start;
	} eng_cmd_t;

	typedef struct packed {
		logic done;
	} eng_stat_t;

	// atan(2^-i) in degrees with TabFrac fraction bits.
	function automatic logic [31:0] atan_deg(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0:  r = 32'd754974720;
				5'd1:  r = 32'd445687602;
				5'd2:  r = 32'd235489088;
				5'd3:  r = 32'd119537938;
				5'd4:  r = 32'd60000934;
				5'd5:  r = 32'd30029717;
				5'd6:  r = 32'd15018523;
				5'd7:  r = 32'd7509720;
				5'd8:  r = 32'd3754917;
				5'd9:  r = 32'd1877466;
				5'd10: r = 32'd938734;
				5'd11: r = 32'd469367;
				5'd12: r = 32'd234684;
				5'd13: r = 32'd117342;
				5'd14: r = 32'd58671;
				5'd15: r = 32'd29335;
				5'd16: r = 32'd14668;
				5'd17: r = 32'd7334;
				5'd18: r = 32'd3667;
				5'd19: r = 32'd1833;
				5'd20: r = 32'd917;
				5'd21: r = 32'd458;
				5'd22: r = 32'd229;
				5'd23: r = 32'd115;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

/* rtl/imu_complementary_attitude_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter
// Complementary roll/pitch/yaw filter with three parallel angle lanes.
// ----------------------------------------------------------------------------
// An accepted input beat is captured, then passes through the CORDIC load
// and iterations, a handoff register, the blend load and six base-256 digit
// steps of the divide by 100 in each lane, then the merge into the output
// register, which waits while a held output beat is stalled. The input stalls
// while a sample is in flight, so a new beat is taken only once the last has
// reached the output register. Reset clears the kept angles, registers and
// valid flags.
// ----------------------------------------------------------------------------
module imu_complementary_attitude_filter #(
	parameter int unsigned ANGLE_FRAC_BITS = icaf_pkg::AngleFracBitsDef,
	parameter int unsigned CORDIC_STEPS    = icaf_pkg::CordicStepsDef
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire [icaf_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire [icaf_pkg::CfgDataW-1:0] cfg_data,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire logic signed [15:0]   accel_x,
	input  wire logic signed [15:0]   accel_y,
	input  wire logic signed [15:0]   accel_z,
	input  wire logic signed [15:0]   rate_x,
	input  wire logic signed [15:0]   rate_y,
	input  wire logic signed [15:0]   rate_z,
	output logic                      out_valid,
	input  wire                       out_stall,
	output logic signed [31:0]        accel_g_x,
	output logic signed [31:0]        accel_g_y,
	output logic signed [31:0]        accel_g_z,
	output logic signed [31:0]        rate_dps_x,
	output logic signed [31:0]        rate_dps_y,
	output logic signed [31:0]        rate_dps_z,
	output logic signed [31:0]        roll_deg,
	output logic signed [31:0]        pitch_deg,
	output logic signed [31:0]        yaw_deg
);
	import icaf_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_ATAN, S_BLEND, S_LOAD} state_t;

	state_t state_q;
	logic [1:0] accel_range_q, gyro_range_q;
	logic signed [15:0] aoff_q [3];
	logic signed [15:0] goff_q [3];

	// Offset-corrected counts of the captured sample.
	logic signed [16:0] da_q [3];
	logic signed [16:0] dg_q [3];
	// Raw operands for the three atan2 lanes: roll, pitch, yaw.
	logic signed [16:0] ay_q [3];
	logic signed [16:0] ax_q [3];

	logic signed [31:0] ang_q [3];
	logic signed [31:0] acc_ang [3];
	logic signed [31:0] blend_q [3];
	logic signed [BlendGW-1:0] g [3];

	eng_cmd_t  cord_cmd_q, blend_cmd_q;
	eng_stat_t cord_stat [3];
	eng_stat_t blend_stat [3];

	logic in_acc;
	logic out_free;
	logic cord_done;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign cord_done = cord_stat[0].done && cord_stat[1].done && cord_stat[2].done;

	// Configuration registers; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_range_q <= '0;
			gyro_range_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				aoff_q[i] <= '0;
				goff_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACCEL_RANGE: accel_range_q <= cfg_data[1:0];
				REG_GYRO_RANGE:  gyro_range_q  <= cfg_data[1:0];
				REG_ACCEL_OFF_X: aoff_q[0] <= cfg_data;
				REG_ACCEL_OFF_Y: aoff_q[1] <= cfg_data;
				REG_ACCEL_OFF_Z: aoff_q[2] <= cfg_data;
				REG_GYRO_OFF_X:  goff_q[0] <= cfg_data;
				REG_GYRO_OFF_Y:  goff_q[1] <= cfg_data;
				REG_GYRO_OFF_Z:  goff_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture of one input beat. The atan2 operands use raw counts without
	// the offsets: roll is atan2(-ay, az), pitch atan2(-ax, az) and yaw
	// atan2(-ax, ay).
	always_ff @(posedge clk) begin
		if (in_acc) begin
			da_q[0] <= 17'(accel_x) - 17'(aoff_q[0]);
			da_q[1] <= 17'(accel_y) - 17'(aoff_q[1]);
			da_q[2] <= 17'(accel_z) - 17'(aoff_q[2]);
			dg_q[0] <= 17'(rate_x) - 17'(goff_q[0]);
			dg_q[1] <= 17'(rate_y) - 17'(goff_q[1]);
			dg_q[2] <= 17'(rate_z) - 17'(goff_q[2]);
			ay_q[0] <= -17'(accel_y);
			ax_q[0] <= 17'(accel_z);
			ay_q[1] <= -17'(accel_x);
			ax_q[1] <= 17'(accel_z);
			ay_q[2] <= -17'(accel_x);
			ax_q[2] <= 17'(accel_y);
		end
	end

	// Gyro step per lane: rate*0.004 degrees, rounded half up. Roll and yaw
	// subtract it from the kept angle, pitch adds it.
	always_comb begin
		logic signed [41:0] prod;
		logic signed [41:0] rnd;
		logic signed [BlendGW-1:0] stp;
		for (int i = 0; i < 3; i++) begin
			prod = 42'(dg_q[i]) <<< (32'(gyro_range_q) + 1 + ANGLE_FRAC_BITS);
			rnd  = (prod + 42'sd32768) >>> 16;
			stp  = rnd[BlendGW-1:0];
			g[i] = (i == 1) ? BlendGW'(ang_q[i]) + stp : BlendGW'(ang_q[i]) - stp;
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		icaf_cordic #(
			.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
			.CORDIC_STEPS(CORDIC_STEPS)
		) u_cordic (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cord_cmd_q),
			.y_in  (ay_q[l]),
			.x_in  (ax_q[l]),
			.stat  (cord_stat[l]),
			.angle (acc_ang[l])
		);

		icaf_blend u_blend (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (blend_cmd_q),
			.g     (g[l]),
			.a     (acc_ang[l]),
			.stat  (blend_stat[l]),
			.q     (blend_q[l])
		);
	end

	// Sequencer and merge stage: all lanes run in lockstep, and the kept
	// angles and the output register load together once the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cord_cmd_q  <= '0;
			blend_cmd_q <= '0;
			out_valid   <= 1'b0;
			for (int i = 0; i < 3; i++)
				ang_q[i] <= '0;
		end else begin
			cord_cmd_q.start  <= (state_q == S_IDLE) && in_acc;
			blend_cmd_q.start <= (state_q == S_ATAN) && cord_done;
			if (state_q == S_LOAD && out_free)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc)
						state_q <= S_ATAN;
				end
				S_ATAN: begin
					if (cord_done)
						state_q <= S_BLEND;
				end
				S_BLEND: begin
					if (blend_stat[0].done && blend_stat[1].done && blend_stat[2].done)
						state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (out_free) begin
						for (int i = 0; i < 3; i++)
							ang_q[i] <= blend_q[i];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && out_free) begin
			accel_g_x  <= 32'(da_q[0]) <<< (32'(accel_range_q) + 2);
			accel_g_y  <= 32'(da_q[1]) <<< (32'(accel_range_q) + 2);
			accel_g_z  <= 32'(da_q[2]) <<< (32'(accel_range_q) + 2);
			rate_dps_x <= (32'(dg_q[0]) * 32'sd500) <<< gyro_range_q;
			rate_dps_y <= (32'(dg_q[1]) * 32'sd500) <<< gyro_range_q;
			rate_dps_z <= (32'(dg_q[2]) * 32'sd500) <<< gyro_range_q;
			roll_deg   <= blend_q[0];
			pitch_deg  <= blend_q[1];
			yaw_deg    <= blend_q[2];
		end
	end

endmodule
`default_nettype wire

/* rtl/icaf_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icaf_cordic
// Iterative vectoring CORDIC: atan2(y, x) in degrees, one step per cycle.
// ----------------------------------------------------------------------------
module icaf_cordic #(
	parameter int unsigned ANGLE_FRAC_BITS = 16,
	parameter int unsigned CORDIC_STEPS    = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire icaf_pkg::eng_cmd_t cmd,
	input  wire logic signed [16:0] y_in,
	input  wire logic signed [16:0] x_in,
	output icaf_pkg::eng_stat_t   stat,
	output logic signed [31:0]    angle
);
	import icaf_pkg::*;

	localparam int unsigned CntW = $clog2(CORDIC_STEPS + 1);
	localparam int unsigned Drop = TabFrac - ANGLE_FRAC_BITS;

	logic signed [CordicW-1:0] x_q, y_q, z_q, xs, ys, dx, dy, zr;
	logic [CntW-1:0] cnt_q;
	logic busy_q, zero_q, done_q;

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign zr = (z_q + (CordicW'(1) <<< (Drop - 1))) >>> Drop;
	assign stat.done = done_q;

	always_comb begin
		xs = CordicW'(x_in) <<< 14;
		ys = CordicW'(y_in) <<< 14;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !cmd.start && (cnt_q == CntW'(CORDIC_STEPS - 1));
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CntW'(CORDIC_STEPS - 1))
					busy_q <= 1'b0;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			zero_q <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_q <= ys;
					y_q <= -xs;
					z_q <= CordicW'(90) <<< TabFrac;
				end else begin
					x_q <= -ys;
					y_q <= xs;
					z_q <= -(CordicW'(90) <<< TabFrac);
				end
			end else begin
				x_q <= xs;
				y_q <= ys;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + CordicW'(atan_deg(5'(cnt_q)));
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - CordicW'(atan_deg(5'(cnt_q)));
			end
		end
	end

	assign angle = zero_q ? 32'sd0 : zr[31:0];

endmodule
`default_nettype wire

/* rtl/icaf_blend.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icaf_blend
// Computes (99*g + a)/100 rounded half away from zero, saturated to 32 bits.
// The divide by 100 runs one base-256 digit per cycle by reciprocal multiply.
// ----------------------------------------------------------------------------
module icaf_blend (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire icaf_pkg::eng_cmd_t         cmd,
	input  wire logic signed [icaf_pkg::BlendGW-1:0] g,
	input  wire logic signed [31:0]         a,
	output icaf_pkg::eng_stat_t             stat,
	output logic signed [31:0]              q
);
	import icaf_pkg::*;

	localparam int unsigned NW     = 42;
	localparam int unsigned DivW   = 48;
	localparam int unsigned Digits = DivW / 8;
	localparam int unsigned CntW   = $clog2(Digits + 1);
	// ceil(2^22 / 100); exact quotient for every partial value below 2^15.
	localparam logic [15:0] Recip  = 16'd41944;

	logic signed [NW-1:0] n;
	logic [NW-1:0] mag;
	logic [DivW-1:0] div_q, quo_q;
	logic [6:0] rem_q;
	logic [14:0] part, back;
	logic [30:0] prod;
	logic [7:0] qd;
	logic [CntW-1:0] cnt_q;
	logic busy_q, done_q, neg_q;
	logic signed [DivW:0] sq;

	assign n      = NW'(g) * NW'(99) + NW'(a);
	assign mag    = (n < 0) ? NW'(-n) + NW'(50) : NW'(n) + NW'(50);
	// Remainder so far followed by the next byte of the magnitude.
	assign part   = {rem_q, div_q[DivW-1 -: 8]};
	assign prod   = part * Recip;
	assign qd     = prod[29:22];
	assign back   = 15'(qd) * 15'd100;
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !cmd.start && (cnt_q == CntW'(Digits - 1));
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CntW'(Digits - 1))
					busy_q <= 1'b0;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			div_q <= DivW'(mag);
			neg_q <= n < 0;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			div_q <= {div_q[DivW-9:0], 8'd0};
			quo_q <= {quo_q[DivW-9:0], qd};
			rem_q <= 7'(part - back);
		end
	end

	always_comb begin
		sq = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		if (sq > (DivW+1)'(32'sh7fffffff))
			q = 32'sh7fffffff;
		else if (sq < -(DivW+1)'(64'sh80000000))
			q = 32'sh80000000;
		else
			q = sq[31:0];
	end

endmodule
`default_nettype wire

/* rtl/icaf_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icaf_checker
// Port-level checks of the attitude filter, bound to the top level.
// ----------------------------------------------------------------------------
module icaf_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_stall,
	input wire               out_valid,
	input wire               out_stall,
	input wire signed [31:0] accel_g_x,
	input wire signed [31:0] roll_deg
);

	// A stalled output beat stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(roll_deg))
		else $error("stalled output beat changed");

	// One sample at a time: an accepted beat closes the input.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a sample is in flight");

	// A new result only appears after the input side was busy.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work");

	// Acceleration in g is a count shifted by at least two bits.
	a_accel_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> accel_g_x[1:0] == 2'b00)
		else $error("acceleration scaling broken");

endmodule

bind imu_complementary_attitude_filter icaf_checker u_icaf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.accel_g_x(accel_g_x),
	.roll_deg (roll_deg)
);
`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the attitude filter against a bit-exact SystemVerilog predictor of
// the scaling, CORDIC angles and complementary blend, with random idling on
// both channels, several register settings and a long receiver hold-off.
// ----------------------------------------------------------------------------

// One output beat of the filter.
typedef struct {
	logic signed [31:0] f[9];
} attitude_t;

// Holds the predicted beats in order and compares accepted output beats.
class attitude_board;
	attitude_t pending[$];
	int errors = 0;

	function void note_sample(attitude_t a);
		pending.push_back(a);
	endfunction

	function void check_beat(attitude_t got);
		attitude_t want;
		string names[9] = '{"accel_g_x", "accel_g_y", "accel_g_z", "rate_dps_x",
			"rate_dps_y", "rate_dps_z", "roll_deg", "pitch_deg", "yaw_deg"};
		if (pending.size() == 0) begin
			$error("output beat with nothing expected");
			errors++;
			return;
		end
		want = pending.pop_front();
		for (int i = 0; i < 9; i++) begin
			if (got.f[i] !== want.f[i]) begin
				$error("%s: expected %0d, got %0d", names[i], want.f[i], got.f[i]);
				errors++;
			end
		end
	endfunction
endclass

module testbench;
	import icaf_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] sample[6];
	logic out_valid;
	logic out_stall;
	logic signed [31:0] res[9];

	imu_complementary_attitude_filter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.accel_x(sample[0]), .accel_y(sample[1]), .accel_z(sample[2]),
		.rate_x(sample[3]), .rate_y(sample[4]), .rate_z(sample[5]),
		.out_valid(out_valid), .out_stall(out_stall),
		.accel_g_x(res[0]), .accel_g_y(res[1]), .accel_g_z(res[2]),
		.rate_dps_x(res[3]), .rate_dps_y(res[4]), .rate_dps_z(res[5]),
		.roll_deg(res[6]), .pitch_deg(res[7]), .yaw_deg(res[8])
	);

	attitude_board board = new();

	// Predictor copy of the registers and the kept angles.
	logic [1:0] accel_rng, gyro_rng;
	logic signed [15:0] accel_bias[3], gyro_bias[3];
	logic signed [31:0] kept[3];

	bit quiet_tail;      // no idling in the last part of the run
	bit hold_receiver;   // long receiver hold-off request
	bit hold_done;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Arithmetic shift right on 64-bit values.
	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	// Angle of (x, y) in degrees by vectoring CORDIC, Q16.16 result.
	function automatic longint cordic_deg(longint y, longint x);
		longint z, t, dx, dy;
		longint tab[16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
			30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
			234684, 117342, 58671, 29335};
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		x = x * 16384;
		y = y * 16384;
		// Bring a left half-plane vector into the right half by a quarter turn.
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 64'sd90 <<< 24;
			end else begin
				x = -y; y = t; z = -(64'sd90 <<< 24);
			end
		end
		for (int i = 0; i < 16; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += tab[i];
			end else begin
				x -= dx; y += dy; z -= tab[i];
			end
		end
		return shr(z + 128, 8);
	endfunction

	// Weighted average 0.99/0.01, rounded half away from zero, saturated.
	function automatic logic signed [31:0] mix(longint g, longint a);
		longint n, q;
		n = 99 * g + a;
		q = (n >= 0 ? n + 50 : n - 50) / 100;
		if (q > 64'sd2147483647) return 32'sh7fffffff;
		if (q < -64'sd2147483648) return 32'sh80000000;
		return q[31:0];
	endfunction

	function automatic attitude_t predict_attitude(logic signed [15:0] s[6]);
		attitude_t r;
		longint da, dr, step[3], ang[3];
		for (int i = 0; i < 3; i++) begin
			da = longint'(s[i]) - longint'(accel_bias[i]);
			dr = longint'(s[3+i]) - longint'(gyro_bias[i]);
			r.f[i] = 32'(da <<< (2 + accel_rng));
			r.f[3+i] = 32'((dr * 500) <<< gyro_rng);
			step[i] = shr((dr <<< (gyro_rng + 17)) + 32768, 16);
		end
		// Accelerometer angles use raw counts, without offsets.
		ang[0] = cordic_deg(-longint'(s[1]), s[2]);
		ang[1] = cordic_deg(-longint'(s[0]), s[2]);
		ang[2] = cordic_deg(-longint'(s[0]), s[1]);
		kept[0] = mix(longint'(kept[0]) - step[0], ang[0]);
		kept[1] = mix(longint'(kept[1]) + step[1], ang[1]);
		kept[2] = mix(longint'(kept[2]) - step[2], ang[2]);
		for (int i = 0; i < 3; i++)
			r.f[6+i] = kept[i];
		return r;
	endfunction

	// One register write, after which the write enable is low again before the task returns.
	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_ACCEL_RANGE: accel_rng = val[1:0];
			REG_GYRO_RANGE:  gyro_rng = val[1:0];
			REG_ACCEL_OFF_X: accel_bias[0] = val;
			REG_ACCEL_OFF_Y: accel_bias[1] = val;
			REG_ACCEL_OFF_Z: accel_bias[2] = val;
			REG_GYRO_OFF_X:  gyro_bias[0] = val;
			REG_GYRO_OFF_Y:  gyro_bias[1] = val;
			REG_GYRO_OFF_Z:  gyro_bias[2] = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Drops the input valid, waits for every expected beat, then lets the clock
	// run idle before it returns.
	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Offers one sample, possibly after an idle burst, until it is accepted.
	// The valid stays high afterwards so that beats can follow back to back.
	task automatic send_sample(logic signed [15:0] s[6]);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		for (int i = 0; i < 6; i++)
			sample[i] <= s[i];
		in_valid <= 1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_sample(predict_attitude(s));
	endtask

	function automatic logic [15:0] rand_count();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 8)) - 4);
			3: return 16'($signed($urandom_range(0, 33000)) - 16500);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_phase(int count);
		logic signed [15:0] s[6];
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 6; i++)
				s[i] = rand_count();
			// Put the tilt on an axis now and then so that an atan2 operand is zero.
			if ($urandom_range(0, 7) == 0)
				s[$urandom_range(0, 2)] = 0;
			send_sample(s);
		end
	endtask

	// The receiver stalls in random bursts, once holds off for a long stretch,
	// and keeps its stall low in the quiet tail.
	initial begin
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_receiver && !hold_done) begin
				out_stall <= 1;
				repeat (400) @(posedge clk);
				out_stall <= 0;
				hold_done = 1;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	// Output beats are compared at the edge where they are accepted.
	always @(posedge clk) begin
		attitude_t got;
		if (arst_n && out_valid && !out_stall) begin
			for (int i = 0; i < 9; i++)
				got.f[i] = res[i];
			board.check_beat(got);
		end
	end

	initial begin
		logic signed [15:0] s[6];
		logic signed [15:0] corner[6][6];
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		in_valid = 0;
		for (int i = 0; i < 6; i++)
			sample[i] = 0;
		accel_rng = 0;
		gyro_rng = 0;
		for (int i = 0; i < 3; i++) begin
			accel_bias[i] = 0;
			gyro_bias[i] = 0;
			kept[i] = 0;
		end
		quiet_tail = 0;
		hold_receiver = 0;
		hold_done = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part at reset settings: zero vectors, both atan2 operands
		// zero, zero y with negative x (the +180 degree case) and full scale.
		corner = '{
			'{0, 0, 0, 0, 0, 0},
			'{0, 0, -100, 0, 0, 0},
			'{0, 0, 16384, 1, -1, 0},
			'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
			'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
			'{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff}};
		for (int k = 0; k < 6; k++)
			send_sample(corner[k]);
		s = '{16'sh7fff, 0, 0, 0, 0, 0};
		send_sample(s);
		s = '{16'sh8000, 0, 0, 0, 0, 0};
		send_sample(s);
		s = '{0, 16'sh8000, 0, 0, 0, 0};
		send_sample(s);
		drain();

		// Extreme settings: largest ranges and offsets at both ends.
		write_reg(REG_ACCEL_RANGE, 16'hfff3);
		write_reg(REG_GYRO_RANGE, 16'h0003);
		write_reg(REG_ACCEL_OFF_X, 16'h8000);
		write_reg(REG_ACCEL_OFF_Y, 16'h7fff);
		write_reg(REG_ACCEL_OFF_Z, 16'h8000);
		write_reg(REG_GYRO_OFF_X, 16'h7fff);
		write_reg(REG_GYRO_OFF_Y, 16'h8000);
		write_reg(REG_GYRO_OFF_Z, 16'h7fff);
		for (int k = 3; k < 6; k++)
			send_sample(corner[k]);
		// Full gyro rate for six beats moves the kept angles by the largest steps.
		s = '{0, 0, 100, 16'sh8000, 16'sh7fff, 16'sh8000};
		repeat (6) send_sample(s);
		drain();

		// Random phases, each under a fresh random setting. The sender pauses
		// until the block has delivered everything before each change.
		for (int p = 0; p < 4; p++) begin
			drain();
			write_reg(REG_ACCEL_RANGE, 16'($urandom));
			write_reg(REG_GYRO_RANGE, 16'($urandom));
			for (int r = 0; r < 6; r++)
				write_reg(cfg_reg_t'(REG_ACCEL_OFF_X + r),
					(p == 0) ? 16'd0 : 16'($signed($urandom_range(0, 400)) - 200));
			if (p == 1)
				hold_receiver = 1;
			random_phase(90);
		end
		drain();

		// Reset settings again, then a tail with no idling at all.
		write_reg(REG_ACCEL_RANGE, 0);
		write_reg(REG_GYRO_RANGE, 0);
		for (int r = 0; r < 6; r++)
			write_reg(cfg_reg_t'(REG_ACCEL_OFF_X + r), 0);
		quiet_tail = 1;
		random_phase(60);

		drain();
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog: time for roughly 450 beats plus idling and stalls, many times
	// over.
	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* filelist.f */
rtl/icaf_pkg.sv
rtl/icaf_cordic.sv
rtl/icaf_blend.sv
rtl/imu_complementary_attitude_filter.sv
rtl/icaf_checker.sv
test/testbench.sv
